### rtl/dcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcp_pkg: shared types and constants of the control point decoder
// record kinds, parser phases, the command passed from parser to accumulator
// ----------------------------------------------------------------------------
package dcp_pkg;

    // record kinds on the output tuser
    localparam logic [1:0] KIND_SIZE   = 2'd0;
    localparam logic [1:0] KIND_BRANCH = 2'd1;
    localparam logic [1:0] KIND_POINT  = 2'd2;
    localparam logic [1:0] KIND_END    = 2'd3;

    // parser phases
    localparam logic [2:0] PH_FLAG    = 3'd0;
    localparam logic [2:0] PH_SIZE    = 3'd1;
    localparam logic [2:0] PH_HEADER  = 3'd2;
    localparam logic [2:0] PH_SAMPLES = 3'd3;
    localparam logic [2:0] PH_PTHEAD  = 3'd4;
    localparam logic [2:0] PH_LONG    = 3'd5;
    localparam logic [2:0] PH_SHORTR  = 3'd6;
    localparam logic [2:0] PH_DONE    = 3'd7;

    localparam logic [7:0]  END_MARK    = 8'd255;
    localparam logic [15:0] LONG_MARK   = 16'd25700;
    localparam logic [7:0]  SHORT_LIMIT = 8'd128;
    localparam logic [15:0] LONG_LIMIT  = 16'd32768;

    localparam int DELTA_W = 17;
    localparam int SUM_W   = 32;
    localparam int TDATA_W = 152;

    typedef logic signed [DELTA_W-1:0] t_delta;

    // one decoded record request, fields not used by the kind are zero
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] width;
        logic [15:0] height;
        logic [3:0]  points;
        logic [3:0]  degree;
        logic [15:0] samples;
        t_delta      dx;
        t_delta      dy;
        t_delta      dr;
    } t_cmd;

    // queue hand-off between parser and accumulator
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_req;

    // 8-bit delta, 128 stays positive
    function automatic t_delta ext8(input logic [7:0] v);
        logic neg;
        neg = (v > SHORT_LIMIT);
        return {{(DELTA_W - 8){neg}}, v};
    endfunction

    // 16-bit delta, 32768 stays positive
    function automatic t_delta ext16(input logic [15:0] v);
        logic neg;
        neg = (v > LONG_LIMIT);
        return {{(DELTA_W - 16){neg}}, v};
    endfunction

endpackage

### rtl/dcp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcp_front: byte stream parser
// walks the file layout one byte per accepted cycle and issues record requests
// ----------------------------------------------------------------------------
module dcp_front
    import dcp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  logic [7:0] i_byte,
    output t_cmd_req o_req
);

    logic [2:0] r_phase, n_phase;
    logic [2:0] r_idx, n_idx;
    logic [3:0] r_left, n_left;
    logic [7:0] r_held [5];
    logic [7:0] r_header;
    logic       w_hold_we;
    logic [2:0] w_hold_addr;
    logic       w_header_we;
    t_cmd_req   w_req;

    always_comb begin
        n_phase     = r_phase;
        n_idx       = r_idx;
        n_left      = r_left;
        w_hold_we   = 1'b0;
        w_hold_addr = r_idx;
        w_header_we = 1'b0;
        w_req       = '0;
        if (i_accept) begin
            case (r_phase)
                PH_FLAG: begin
                    n_phase = PH_SIZE;
                    n_idx   = 3'd0;
                end
                PH_SIZE: begin
                    if (r_idx < 3'd3) begin
                        w_hold_we = 1'b1;
                        n_idx     = r_idx + 3'd1;
                    end else begin
                        w_req.valid      = 1'b1;
                        w_req.cmd.kind   = KIND_SIZE;
                        w_req.cmd.width  = {r_held[0], r_held[1]};
                        w_req.cmd.height = {r_held[2], i_byte};
                        n_idx            = 3'd0;
                        n_phase          = PH_HEADER;
                    end
                end
                PH_HEADER: begin
                    if (i_byte == END_MARK) begin
                        w_req.valid    = 1'b1;
                        w_req.cmd.kind = KIND_END;
                        n_phase        = PH_DONE;
                    end else begin
                        w_header_we = 1'b1;
                        n_idx       = 3'd0;
                        n_phase     = PH_SAMPLES;
                    end
                end
                PH_SAMPLES: begin
                    if (r_idx == 3'd0) begin
                        w_hold_we = 1'b1;
                        n_idx     = 3'd1;
                    end else begin
                        w_req.valid       = 1'b1;
                        w_req.cmd.kind    = KIND_BRANCH;
                        w_req.cmd.points  = r_header[7:4];
                        w_req.cmd.degree  = r_header[3:0];
                        w_req.cmd.samples = {r_held[0], i_byte};
                        n_left            = r_header[7:4];
                        n_idx             = 3'd0;
                        n_phase           = (r_header[7:4] == 4'd0) ? PH_HEADER : PH_PTHEAD;
                    end
                end
                PH_PTHEAD: begin
                    w_hold_we = 1'b1;
                    if (r_idx == 3'd0) begin
                        n_idx = 3'd1;
                    end else begin
                        n_idx   = 3'd0;
                        n_phase = ({r_held[0], i_byte} == LONG_MARK) ? PH_LONG : PH_SHORTR;
                    end
                end
                PH_LONG: begin
                    if (r_idx < 3'd5) begin
                        w_hold_we = 1'b1;
                        n_idx     = r_idx + 3'd1;
                    end else begin
                        w_req.valid    = 1'b1;
                        w_req.cmd.kind = KIND_POINT;
                        w_req.cmd.dx   = ext16({r_held[0], r_held[1]});
                        w_req.cmd.dy   = ext16({r_held[2], r_held[3]});
                        w_req.cmd.dr   = ext16({r_held[4], i_byte});
                        n_left         = r_left - 4'd1;
                        n_idx          = 3'd0;
                        n_phase        = (r_left == 4'd1) ? PH_HEADER : PH_PTHEAD;
                    end
                end
                PH_SHORTR: begin
                    w_req.valid    = 1'b1;
                    w_req.cmd.kind = KIND_POINT;
                    w_req.cmd.dx   = ext8(r_held[0]);
                    w_req.cmd.dy   = ext8(r_held[1]);
                    w_req.cmd.dr   = ext8(i_byte);
                    n_left         = r_left - 4'd1;
                    n_idx          = 3'd0;
                    n_phase        = (r_left == 4'd1) ? PH_HEADER : PH_PTHEAD;
                end
                default: begin
                    // after the end mark every byte is dropped
                    n_phase = PH_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FLAG;
            r_idx   <= 3'd0;
            r_left  <= 4'd0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_left  <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_hold_we) begin
            r_held[w_hold_addr] <= i_byte;
        end
        if (w_header_we) begin
            r_header <= i_byte;
        end
    end

    assign o_req = w_req;

endmodule

### rtl/dcp_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcp_fifo: two-entry request queue
// decouples the parser from the accumulator and output stage
// ----------------------------------------------------------------------------
module dcp_fifo
    import dcp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cmd_req i_push,
    input  logic     i_pop,
    output logic     o_full,
    output t_cmd_req o_head
);

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_pop;

    assign w_pop = i_pop && (r_count != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push.valid && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push.valid && w_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.cmd;
        end
    end

    assign o_full       = (r_count == 2'd2);
    assign o_head.valid = (r_count != 2'd0);
    assign o_head.cmd   = r_mem[r_rd_ptr];

endmodule

### rtl/dcp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcp_back: running sums and output register
// applies point deltas and holds one finished record for the sink
// ----------------------------------------------------------------------------
module dcp_back
    import dcp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd_req           i_head,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_kind,
    output logic [TDATA_W-1:0] o_data
);

    logic [SUM_W-1:0]   r_sum_x, r_sum_y, r_sum_r;
    logic [SUM_W-1:0]   n_sum_x, n_sum_y, n_sum_r;
    logic               r_valid;
    logic [1:0]         r_kind;
    logic [TDATA_W-1:0] r_data, n_data;
    logic               w_pop;
    logic               w_point;

    assign w_pop   = i_head.valid && (!r_valid || i_ready);
    assign w_point = (i_head.cmd.kind == KIND_POINT);

    always_comb begin
        n_sum_x = r_sum_x + SUM_W'(i_head.cmd.dx);
        n_sum_y = r_sum_y + SUM_W'(i_head.cmd.dy);
        n_sum_r = r_sum_r + SUM_W'(i_head.cmd.dr);
        n_data  = '0;
        case (i_head.cmd.kind)
            KIND_SIZE: begin
                n_data[15:0]  = i_head.cmd.width;
                n_data[31:16] = i_head.cmd.height;
            end
            KIND_BRANCH: begin
                n_data[35:32] = i_head.cmd.points;
                n_data[39:36] = i_head.cmd.degree;
                n_data[55:40] = i_head.cmd.samples;
            end
            KIND_POINT: begin
                n_data[87:56]   = n_sum_x;
                n_data[119:88]  = n_sum_y;
                n_data[151:120] = n_sum_r;
            end
            default: begin
                n_data = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sum_x <= '0;
            r_sum_y <= '0;
            r_sum_r <= '0;
        end else begin
            if (w_pop) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            if (w_pop && w_point) begin
                r_sum_x <= n_sum_x;
                r_sum_y <= n_sum_y;
                r_sum_r <= n_sum_r;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_kind <= i_head.cmd.kind;
            r_data <= n_data;
        end
    end

    assign o_pop   = w_pop;
    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_data  = r_data;

endmodule

### rtl/delta_control_point_decoder.sv
`timescale 1ns / 1ps
// a completed record is written into the request queue, then popped into the output register once that is free
// throughput: one byte per cycle while the request queue is not full; each byte is one parser phase step
// and each record one pass through the accumulator adders
// a two-entry request queue lets the parser run on while the output register is stalled
// reset (i_rst_n low, synchronous) returns to the flag byte and clears the running sums
// ----------------------------------------------------------------------------
// delta_control_point_decoder: delta coded control point stream decoder
// parses size, branch and point records from a byte stream and accumulates
// point deltas into running x, y and radius coordinates
// ----------------------------------------------------------------------------
module delta_control_point_decoder
    import dcp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // slave side: one file byte per request
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [7:0]         i_s_tdata,   // [7:0] stream_byte
    // master side: one record per request
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [1:0]         o_m_tuser,   // [1:0] record_kind
    // [15:0] image_width, [31:16] image_height, [35:32] branch_points,
    // [39:36] branch_degree, [55:40] branch_samples, [87:56] point_x,
    // [119:88] point_y, [151:120] point_radius
    output logic [TDATA_W-1:0] o_m_tdata
);

    logic     w_accept;
    logic     w_full;
    logic     w_pop;
    t_cmd_req w_push;
    t_cmd_req w_head;

    // the parser only stalls when the queue holds two waiting records
    assign o_s_tready = !w_full;
    assign w_accept   = i_s_tvalid && !w_full;

    // front: phase tracking, byte assembly, delta sign handling
    dcp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (i_s_tdata),
        .o_req    (w_push)
    );

    // queue between parser and accumulator
    dcp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_head  (w_head)
    );

    // back: running sums and registered output
    dcp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_kind  (o_m_tuser),
        .o_data  (o_m_tdata)
    );

    // a full queue can only build up behind a held output record
    a_full_means_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> o_m_tvalid)
        else $error("queue full with empty output register");

    // a popped point request shows up as a point record
    a_point_reaches_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && w_head.cmd.kind == KIND_POINT) |=> (o_m_tvalid && o_m_tuser == KIND_POINT))
        else $error("point request lost between queue and output");

    // coordinate fields stay zero outside point records
    a_coords_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != KIND_POINT) |-> (o_m_tdata[151:56] == '0))
        else $error("coordinates set in a non-point record");

    // nothing is pushed while the queue is full
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> !w_push.valid)
        else $error("request pushed into a full queue");

endmodule
